// ===== design/ptts_pkg.sv =====
// Shared types and constants for the periodic task tick scheduler.
// This package has no dependencies. The picker and the top level use it.
package ptts_pkg;

  // Table size and time width.
  localparam int MAX_TASKS     = 8;
  localparam int TIME_BITS     = 16;
  localparam int TASK_IDX_BITS = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int KEY_BITS      = TIME_BITS + 1;
  localparam int COUNT_BITS    = 4;

  typedef logic [TIME_BITS-1:0]     time_t;
  typedef logic [KEY_BITS-1:0]      key_t;
  typedef logic [TASK_IDX_BITS-1:0] task_idx_t;

  // Operation codes carried by an input beat.
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_RESTART = 2'd1,
    OP_TICK    = 2'd2
  } op_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_POLICY     = 2'd0,
    CFG_TASK_COUNT = 2'd1,
    CFG_WINDOW     = 2'd2
  } cfg_e;

  // Outcome of the ready-task selection.
  typedef struct packed {
    logic      found;
    task_idx_t idx;
  } pick_t;

endpackage

// ===== design/ptts_pick.sv =====
// Priority picker: chooses the ready task with the smallest key.
// Depends on ptts_pkg. Ties go to the lower task index.
module ptts_pick (
  input  logic [ptts_pkg::MAX_TASKS-1:0] ready_i,
  input  ptts_pkg::key_t                 key_i [ptts_pkg::MAX_TASKS],
  output ptts_pkg::pick_t                pick_o
);

  localparam int Leaves = 1 << ptts_pkg::TASK_IDX_BITS;

  logic                nd_valid [Leaves];
  ptts_pkg::key_t      nd_key   [Leaves];
  ptts_pkg::task_idx_t nd_idx   [Leaves];

  // Balanced compare tree. At each level the right node wins when it is ready
  // and the left is not or it is strictly smaller; ties keep the lower index.
  always_comb begin
    for (int j = 0; j < Leaves; j++) begin
      if (j < ptts_pkg::MAX_TASKS) begin
        nd_valid[j] = ready_i[j];
        nd_key[j]   = key_i[j];
      end else begin
        nd_valid[j] = 1'b0;
        nd_key[j]   = '0;
      end
      nd_idx[j] = ptts_pkg::TASK_IDX_BITS'(j);
    end
    for (int s = 1; s < Leaves; s = s * 2) begin
      for (int j = 0; j + s < Leaves; j = j + 2 * s) begin
        if (nd_valid[j + s] && (!nd_valid[j] || (nd_key[j + s] < nd_key[j]))) begin
          nd_valid[j] = 1'b1;
          nd_key[j]   = nd_key[j + s];
          nd_idx[j]   = nd_idx[j + s];
        end
      end
    end
    pick_o.found = nd_valid[0];
    pick_o.idx   = nd_valid[0] ? nd_idx[0] : '0;
  end

endmodule

// ===== design/periodic_task_tick_scheduler.sv =====
// Top level of the periodic task tick scheduler (RM or EDF policy).
// Depends on ptts_pkg and instantiates ptts_pick for the task selection.
//
// Each input beat is captured in an input register and handled, once the
// result slot is free, by one pass of logic. A tick inside the window
// releases due tasks, picks one ready task (shortest period in RM mode,
// earliest absolute deadline in EDF mode, lower index on ties) and charges
// it one unit; a tick past the window only flags window_over. The result
// beat is registered. The block takes one item per clock cycle while the
// result is not stalled. A stalled result holds the input register, and the
// input stalls once both registers are full. The release step and the
// eight-entry compare tree are combinational.
// Every item gives exactly one result beat.
// Configuration writes are always ready and should be made while idle.
module periodic_task_tick_scheduler (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [1:0]                         cfg_index_i,
  input  logic [15:0]                        cfg_data_i,
  // Input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         opcode_i,
  input  logic [2:0]                         task_index_i,
  input  logic [15:0]                        job_units_i,
  input  logic [15:0]                        period_i,
  input  logic [15:0]                        rel_deadline_i,
  // Output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [15:0]                        tick_time_o,
  output logic [2:0]                         ran_task_o,
  output logic                               task_ran_o,
  output logic                               window_over_o
);

  localparam int N = ptts_pkg::MAX_TASKS;

  // Configuration registers.
  logic                              policy_q;
  logic [ptts_pkg::COUNT_BITS-1:0]   task_count_q;
  ptts_pkg::time_t                   window_q;

  // Input register.
  logic                in_valid_q;
  logic [1:0]          op_q;
  logic [2:0]          idx_q;
  ptts_pkg::time_t     exec_q;
  ptts_pkg::time_t     period_q;
  ptts_pkg::time_t     rel_q;

  // Task table (no reset, written by loads).
  ptts_pkg::time_t     job_len_q [N];
  ptts_pkg::time_t     per_q     [N];
  ptts_pkg::time_t     rel_dl_q  [N];

  // Runtime state.
  ptts_pkg::time_t     work_q [N];
  ptts_pkg::time_t     work_d [N];
  ptts_pkg::key_t      dl_q   [N];
  ptts_pkg::key_t      dl_d   [N];
  ptts_pkg::time_t     cnt_q  [N];
  ptts_pkg::time_t     cnt_d  [N];
  ptts_pkg::time_t     time_q;
  ptts_pkg::time_t     time_d;

  // Release stage values and selection.
  ptts_pkg::time_t     work_rel [N];
  ptts_pkg::key_t      dl_rel   [N];
  ptts_pkg::time_t     cnt_rel  [N];
  ptts_pkg::key_t      key      [N];
  logic [N-1:0]        active;
  logic [N-1:0]        ready;
  ptts_pkg::pick_t     pick;

  // Result register.
  logic                out_valid_q;
  ptts_pkg::time_t     res_tick_d, res_tick_q;
  logic [2:0]          res_ran_d, res_ran_q;
  logic                res_did_d, res_did_q;
  logic                res_over_d, res_over_q;

  logic                advance;
  logic                proc;
  logic                over;

  // Handshake: the input register moves on whenever the result slot is free.
  assign advance    = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign cfg_ready_o = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q     <= 1'b0;
      task_count_q <= ptts_pkg::COUNT_BITS'(1);
      window_q     <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ptts_pkg::CFG_POLICY:     policy_q     <= cfg_data_i[0];
        ptts_pkg::CFG_TASK_COUNT: task_count_q <= cfg_data_i[ptts_pkg::COUNT_BITS-1:0];
        ptts_pkg::CFG_WINDOW:     window_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q     <= opcode_i;
      idx_q    <= task_index_i;
      exec_q   <= job_units_i;
      period_q <= period_i;
      rel_q    <= rel_deadline_i;
    end
  end

  // Release step for every entry that takes part, then the picker keys.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      active[i]   = ptts_pkg::COUNT_BITS'(i) < task_count_q;
      work_rel[i] = work_q[i];
      dl_rel[i]   = dl_q[i];
      cnt_rel[i]  = cnt_q[i];
      if (active[i]) begin
        if (cnt_q[i] == '0) begin
          work_rel[i] = job_len_q[i];
          dl_rel[i]   = {1'b0, time_q} + {1'b0, rel_dl_q[i]};
          cnt_rel[i]  = (per_q[i] == '0) ? '0 : per_q[i] - 1'b1;
        end else begin
          cnt_rel[i]  = cnt_q[i] - 1'b1;
        end
      end
      ready[i] = active[i] && (work_rel[i] != '0);
      key[i]   = policy_q ? dl_rel[i] : {1'b0, per_q[i]};
    end
  end

  ptts_pick u_pick (
    .ready_i (ready),
    .key_i   (key),
    .pick_o  (pick)
  );

  assign over = time_q >= window_q;

  // Next state and result for the item in the input register.
  always_comb begin
    work_d     = work_q;
    dl_d       = dl_q;
    cnt_d      = cnt_q;
    time_d     = time_q;
    res_tick_d = time_q;
    res_ran_d  = '0;
    res_did_d  = 1'b0;
    res_over_d = 1'b0;
    case (op_q)
      ptts_pkg::OP_LOAD: begin
        work_d[idx_q] = '0;
        dl_d[idx_q]   = '0;
        cnt_d[idx_q]  = '0;
      end
      ptts_pkg::OP_RESTART: begin
        for (int i = 0; i < N; i++) begin
          work_d[i] = '0;
          dl_d[i]   = '0;
          cnt_d[i]  = '0;
        end
        time_d     = '0;
        res_tick_d = '0;
      end
      ptts_pkg::OP_TICK: begin
        if (over) begin
          res_over_d = 1'b1;
        end else begin
          work_d = work_rel;
          dl_d   = dl_rel;
          cnt_d  = cnt_rel;
          if (pick.found) begin
            work_d[pick.idx] = work_rel[pick.idx] - 1'b1;
          end
          res_ran_d = pick.idx;
          res_did_d = pick.found;
          time_d    = time_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Runtime state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        work_q[i] <= '0;
        dl_q[i]   <= '0;
        cnt_q[i]  <= '0;
      end
      time_q <= '0;
    end else if (proc) begin
      work_q <= work_d;
      dl_q   <= dl_d;
      cnt_q  <= cnt_d;
      time_q <= time_d;
    end
  end

  // Task table writes by load beats.
  always_ff @(posedge clk_i) begin
    if (proc && (op_q == ptts_pkg::OP_LOAD)) begin
      job_len_q[idx_q] <= exec_q;
      per_q[idx_q]     <= period_q;
      rel_dl_q[idx_q]  <= rel_q;
    end
  end

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (proc) begin
      res_tick_q <= res_tick_d;
      res_ran_q  <= res_ran_d;
      res_did_q  <= res_did_d;
      res_over_q <= res_over_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tick_time_o   = res_tick_q;
  assign ran_task_o    = res_ran_q;
  assign task_ran_o    = res_did_q;
  assign window_over_o = res_over_q;

`ifndef SYNTH
  // A result beat never reports both a charged task and an expired window.
  a_run_over_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(task_ran_o && window_over_o))
    else $error("task ran and window over in one beat");

  // An idle or non-tick beat reports task index zero.
  a_idle_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !task_ran_o) |-> (ran_task_o == '0))
    else $error("nonzero task index without a charged task");

  // The picked task always has work left after the release step.
  a_pick_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pick.found |-> ready[pick.idx])
    else $error("picker chose a task that is not ready");

  // A restart clears time.
  a_restart_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && (op_q == ptts_pkg::OP_RESTART)) |=> (time_q == '0))
    else $error("time not cleared by restart");

  // A tick inside the window advances time by exactly one.
  a_tick_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && (op_q == ptts_pkg::OP_TICK) && !over) |=>
      (time_q == $past(time_q) + 1'b1))
    else $error("time did not advance on a tick");
`endif

endmodule

// ===== dv/periodic_task_tick_scheduler_test.sv =====
// Self-checking testbench for the periodic task tick scheduler (RM and EDF policies).
// It depends on ptts_pkg and the periodic_task_tick_scheduler RTL. An in-bench model
// of the task table predicts every result beat under random handshake pressure.
module periodic_task_tick_scheduler_test;

  // Opcode value that the block must ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int STUCK_LIMIT = 1000;
  localparam int LONG_HOLD = 80;

  typedef struct packed {
    logic [1:0]          opcode;
    ptts_pkg::task_idx_t task_index;
    logic [15:0]         job_units;
    logic [15:0]         period;
    logic [15:0]         rel_deadline;
  } sched_item_t;

  typedef struct packed {
    ptts_pkg::time_t     tick_time;
    ptts_pkg::task_idx_t ran_task;
    logic                task_ran;
    logic                window_over;
  } sched_result_t;

  // Tracks the task table, computes each expected result beat and checks actual ones.
  class sched_scoreboard;
    bit              edf_mode;
    int unsigned     active_tasks;
    ptts_pkg::time_t window_len;
    ptts_pkg::time_t job_len[ptts_pkg::MAX_TASKS];
    ptts_pkg::time_t release_gap[ptts_pkg::MAX_TASKS];
    ptts_pkg::time_t deadline_offset[ptts_pkg::MAX_TASKS];
    ptts_pkg::time_t work_left[ptts_pkg::MAX_TASKS];
    ptts_pkg::time_t countdown[ptts_pkg::MAX_TASKS];
    ptts_pkg::key_t  due_at[ptts_pkg::MAX_TASKS];
    ptts_pkg::time_t now;
    sched_result_t   expected_q[$];
    int              errors;

    function new();
      edf_mode = 1'b0;
      active_tasks = 1;
      window_len = 16'hFFFF;
      for (int i = 0; i < ptts_pkg::MAX_TASKS; i++) begin
        job_len[i] = '0;
        release_gap[i] = '0;
        deadline_offset[i] = '0;
        work_left[i] = '0;
        countdown[i] = '0;
        due_at[i] = '0;
      end
      now = '0;
      errors = 0;
    endfunction

    function void set_reg(ptts_pkg::cfg_e idx, logic [15:0] val);
      case (idx)
        ptts_pkg::CFG_POLICY:     edf_mode = val[0];
        ptts_pkg::CFG_TASK_COUNT: active_tasks = 32'(val[3:0]);
        ptts_pkg::CFG_WINDOW:     window_len = val;
        default: ;
      endcase
    endfunction

    // Applies one accepted input beat and queues the result it must produce.
    function void note_input(sched_item_t it);
      sched_result_t   r;
      int              n;
      int              best;
      bit              found;
      bit              better;
      ptts_pkg::time_t gap;
      r = '0;
      r.tick_time = now;
      case (it.opcode)
        ptts_pkg::OP_LOAD: begin
          job_len[it.task_index] = it.job_units;
          release_gap[it.task_index] = it.period;
          deadline_offset[it.task_index] = it.rel_deadline;
          work_left[it.task_index] = '0;
          due_at[it.task_index] = '0;
          countdown[it.task_index] = '0;
        end
        ptts_pkg::OP_RESTART: begin
          for (int i = 0; i < ptts_pkg::MAX_TASKS; i++) begin
            work_left[i] = '0;
            due_at[i] = '0;
            countdown[i] = '0;
          end
          now = '0;
          r.tick_time = '0;
        end
        ptts_pkg::OP_TICK: begin
          if (now >= window_len) begin
            r.window_over = 1'b1;
          end else begin
            n = (active_tasks > ptts_pkg::MAX_TASKS) ? ptts_pkg::MAX_TASKS
                                                     : int'(active_tasks);
            // Release every task whose countdown has run out.
            for (int i = 0; i < n; i++) begin
              if (countdown[i] == 0) begin
                gap = (release_gap[i] == 0) ? 16'd1 : release_gap[i];
                work_left[i] = job_len[i];
                due_at[i] = {1'b0, now} + {1'b0, deadline_offset[i]};
                countdown[i] = gap - 16'd1;
              end else begin
                countdown[i] = countdown[i] - 16'd1;
              end
            end
            // Pick one ready task; a strict compare keeps the lower index on ties.
            found = 1'b0;
            best = 0;
            for (int i = 0; i < n; i++) begin
              if (work_left[i] != 0) begin
                if (!found) better = 1'b1;
                else if (!edf_mode) better = release_gap[i] < release_gap[best];
                else better = due_at[i] < due_at[best];
                if (better) begin
                  best = i;
                  found = 1'b1;
                end
              end
            end
            if (found) begin
              work_left[best] = work_left[best] - 16'd1;
              r.ran_task = ptts_pkg::task_idx_t'(best);
              r.task_ran = 1'b1;
            end
            now = now + 16'd1;
          end
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: time %0d task %0d ran %0b over %0b",
                   got.tick_time, got.ran_task, got.task_ran, got.window_over);
        return;
      end
      want = expected_q.pop_front();
      if (got.tick_time !== want.tick_time || got.ran_task !== want.ran_task ||
          got.task_ran !== want.task_ran || got.window_over !== want.window_over) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: expected time %0d task %0d ran %0b over %0b, ",
                    "got time %0d task %0d ran %0b over %0b"},
                   want.tick_time, want.ran_task, want.task_ran, want.window_over,
                   got.tick_time, got.ran_task, got.task_ran, got.window_over);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = '0;
  logic [2:0]  task_index_i = '0;
  logic [15:0] job_units_i = '0;
  logic [15:0] period_i = '0;
  logic [15:0] rel_deadline_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] tick_time_o;
  logic [2:0]  ran_task_o;
  logic        task_ran_o;
  logic        window_over_o;

  sched_scoreboard sb;
  bit sender_quiet = 1'b0;
  bit receiver_quiet = 1'b0;
  bit hold_request = 1'b0;
  int stuck_cycles = 0;

  // Settings of the random phases.
  int plan_policy[8] = '{0, 1, 0, 1, 1, 0, 1, 0};
  int plan_count[8]  = '{8, 8, 1, 3, 15, 0, 5, 8};
  int plan_window[8] = '{65535, 65535, 40, 1, 200, 30, 65535, 300};
  int plan_items[8]  = '{60, 60, 50, 40, 60, 40, 60, 60};

  periodic_task_tick_scheduler DUT (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .opcode_i, .task_index_i, .job_units_i, .period_i,
    .rel_deadline_i,
    .out_valid_o, .out_stall_i, .tick_time_o, .ran_task_o, .task_ran_o, .window_over_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Writes all three registers back to back; only called while the block is idle.
  task automatic write_settings(int policy, int count, int window);
    ptts_pkg::cfg_e idx[3];
    logic [15:0]    val[3];
    idx = '{ptts_pkg::CFG_POLICY, ptts_pkg::CFG_TASK_COUNT, ptts_pkg::CFG_WINDOW};
    val = '{16'(policy), 16'(count), 16'(window)};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Offers one input beat after a random gap and holds it until accepted.
  task automatic send_item(sched_item_t it);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= it.opcode;
    task_index_i <= it.task_index;
    job_units_i <= it.job_units;
    period_i <= it.period;
    rel_deadline_i <= it.rel_deadline;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
  endtask

  task automatic send_fields(logic [1:0] op, int idx, int units, int per, int dl);
    sched_item_t it;
    it.opcode = op;
    it.task_index = ptts_pkg::task_idx_t'(idx);
    it.job_units = 16'(units);
    it.period = 16'(per);
    it.rel_deadline = 16'(dl);
    send_item(it);
  endtask

  // Stops offering beats and waits until every expected result has arrived.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly ticks with loads of small tasks mixed in, plus restarts and unused opcodes.
  function automatic sched_item_t make_random_item();
    sched_item_t it;
    int          pick;
    it.task_index = ptts_pkg::task_idx_t'($urandom_range(0, 7));
    it.job_units = 16'($urandom);
    it.period = 16'($urandom);
    it.rel_deadline = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      it.opcode = ptts_pkg::OP_TICK;
    end else if (pick < 85) begin
      it.opcode = ptts_pkg::OP_LOAD;
      if ($urandom_range(0, 9) != 0) it.job_units = 16'($urandom_range(0, 6));
      pick = $urandom_range(0, 19);
      if (pick == 0) it.period = '0;
      else if (pick > 1) it.period = 16'($urandom_range(1, 12));
      pick = $urandom_range(0, 19);
      if (pick == 0) it.rel_deadline = '0;
      else if (pick > 1) it.rel_deadline = 16'($urandom_range(1, 20));
    end else if (pick < 95) begin
      it.opcode = ptts_pkg::OP_RESTART;
    end else begin
      it.opcode = OP_UNUSED;
    end
    return it;
  endfunction

  // Receiver: a random stall per beat, or one long hold-off when asked.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        n = LONG_HOLD;
      end else begin
        n = receiver_quiet ? 0 : $urandom_range(0, 8);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({tick_time_o, ran_task_o, task_ran_o, window_over_o});
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        stuck_cycles <= 0;
      else
        stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: load the whole table first so no tick reads an unwritten entry.
    write_settings(0, 8, 65535);
    send_fields(ptts_pkg::OP_LOAD, 0, 65535, 65535, 65535);
    send_fields(ptts_pkg::OP_LOAD, 1, 0, 1, 1);
    send_fields(ptts_pkg::OP_LOAD, 2, 2, 0, 0);
    send_fields(ptts_pkg::OP_LOAD, 3, 1, 4, 3);
    for (int i = 4; i < 8; i++) send_fields(ptts_pkg::OP_LOAD, i, 2, 2 + i, 5);
    repeat (4) send_fields(ptts_pkg::OP_TICK, 0, 0, 0, 0);
    send_fields(OP_UNUSED, 7, 65535, 65535, 65535);
    // Reloading a task drops any unfinished job that it had.
    send_fields(ptts_pkg::OP_LOAD, 1, 3, 2, 2);
    repeat (2) send_fields(ptts_pkg::OP_TICK, 5, 16'hAAAA, 16'h5555, 16'hFFFF);
    send_fields(ptts_pkg::OP_RESTART, 0, 0, 0, 0);
    send_fields(ptts_pkg::OP_TICK, 0, 0, 0, 0);
    drain();

    // Directed: EDF with a short window, ticks run past its end, then a restart.
    write_settings(1, 8, 3);
    repeat (4) send_fields(ptts_pkg::OP_TICK, 0, 0, 0, 0);
    send_fields(ptts_pkg::OP_RESTART, 0, 0, 0, 0);
    send_fields(ptts_pkg::OP_TICK, 0, 0, 0, 0);
    drain();

    // Random phases, each under its own register settings.
    for (int p = 0; p < 8; p++) begin
      write_settings(plan_policy[p], plan_count[p], plan_window[p]);
      sender_quiet = (p % 3 == 2);
      receiver_quiet = (p % 3 == 2);
      for (int k = 0; k < plan_items[p]; k++) begin
        if (p == 1 && k == 20) begin
          // Long output hold-off while beats keep coming back to back.
          hold_request = 1'b1;
          sender_quiet = 1'b1;
        end
        if (p == 1 && k == 50) sender_quiet = 1'b0;
        if (p == 4 && k == 30) drain();
        send_item(make_random_item());
      end
      drain();
    end

    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
